/* rtl/core/utf8_truncating_copy_top_assert.svh */
// Assertion macros for the UTF-8 truncating copy block.
// Expects signals clk and rst_n in the scope of the module that uses them.
`ifndef UTF8_TRUNCATING_COPY_TOP_ASSERT_SVH
`define UTF8_TRUNCATING_COPY_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define UTC_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utf8 copy: assertion failed");

// Next-cycle implication, disabled during reset
`define UTC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utf8 copy: assertion failed");

`endif

/* rtl/core/utc_pkg.sv */
// Shared types, constants and the lead-byte decode for the UTF-8 truncating copy.
// No dependencies.
`default_nettype none

package utc_pkg;

    localparam int MAX_BUFFER = 4096;
    localparam int BUF_SIZE_W = 13;
    localparam int POS_W      = 12;
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 3;
    localparam int LEFT_W     = 2;

    localparam logic [BUF_SIZE_W-1:0] BUF_SIZE_RESET = BUF_SIZE_W'(MAX_BUFFER);

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_BUFFER_SIZE  = 1'b0,
        CFG_START_OFFSET = 1'b1
    } cfg_index_t;

    // Run end status
    typedef enum logic [1:0] {
        STAT_COMPLETE  = 2'd0,
        STAT_TRUNCATED = 2'd1,
        STAT_INVALID   = 2'd2
    } status_t;

    // Size and offset after saturation and clamping
    typedef struct packed {
        logic [BUF_SIZE_W-1:0] run_size;
        logic [POS_W-1:0]      run_offset;
    } run_cfg_t;

    // Character length from its lead byte; zero for an invalid lead
    function automatic logic [LEN_W-1:0] utc_lead_length(input logic [BYTE_W-1:0] b);
        logic [LEN_W-1:0] len;
        if ((b & 8'h80) == 8'h00)
            len = 3'd1;
        else if ((b & 8'hE0) == 8'hC0)
            len = 3'd2;
        else if ((b & 8'hF0) == 8'hE0)
            len = 3'd3;
        else if ((b & 8'hF8) == 8'hF0)
            len = 3'd4;
        else
            len = 3'd0;
        return len;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/utc_in_if.sv */
// Source byte stream channel: valid/ready handshake with byte and first flag.
// Depends on utc_pkg.
`default_nettype none

interface utc_in_if;
    logic                        valid;
    logic                        ready;
    logic [utc_pkg::BYTE_W-1:0]  src_byte;
    logic                        first;

    modport source (output valid, output src_byte, output first, input ready);
    modport sink   (input valid, input src_byte, input first, output ready);
endinterface

`default_nettype wire

/* rtl/core/utc_out_if.sv */
// Destination write channel: valid/ready handshake with byte, position and run status.
// Depends on utc_pkg.
`default_nettype none

interface utc_out_if;
    logic                        valid;
    logic                        ready;
    logic [utc_pkg::BYTE_W-1:0]  write_byte;
    logic [utc_pkg::POS_W-1:0]   write_pos;
    logic                        last;
    logic [1:0]                  status;
    logic [utc_pkg::POS_W-1:0]   total_length;

    modport source (output valid, output write_byte, output write_pos, output last,
                    output status, output total_length, input ready);
    modport sink   (input valid, input write_byte, input write_pos, input last,
                    input status, input total_length, output ready);
endinterface

`default_nettype wire

/* rtl/core/utc_cfg_if.sv */
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on utc_pkg.
`default_nettype none

interface utc_cfg_if;
    logic                           valid;
    logic                           ready;
    utc_pkg::cfg_index_t            index;
    logic [utc_pkg::BUF_SIZE_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/utc_cfg_regs.sv */
// Configuration registers with buffer size saturation and offset clamping.
// Depends on utc_pkg and utc_cfg_if.
`default_nettype none

module utc_cfg_regs (
    input  wire               clk,
    input  wire               rst_n,
    utc_cfg_if.sink           cfg,
    output utc_pkg::run_cfg_t run_cfg
);
    import utc_pkg::*;

    logic [BUF_SIZE_W-1:0] buffer_size_reg;
    logic [POS_W-1:0]      start_offset_reg;
    logic [BUF_SIZE_W-1:0] size_sat;
    logic [BUF_SIZE_W-1:0] size_m1;

    // Writes always accepted
    assign cfg.ready = 1'b1;

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_size_reg  <= BUF_SIZE_RESET;
            start_offset_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_BUFFER_SIZE:  buffer_size_reg  <= cfg.data;
                CFG_START_OFFSET: start_offset_reg <= cfg.data[POS_W-1:0];
                default:          ;
            endcase
        end
    end

    // Saturate size to the max buffer, zero means one; clamp offset to size - 1
    always_comb
    begin
        if (buffer_size_reg > BUF_SIZE_W'(MAX_BUFFER))
            size_sat = BUF_SIZE_W'(MAX_BUFFER);
        else if (buffer_size_reg == '0)
            size_sat = BUF_SIZE_W'(1);
        else
            size_sat = buffer_size_reg;

        size_m1            = size_sat - BUF_SIZE_W'(1);
        run_cfg.run_size   = size_sat;
        if ({1'b0, start_offset_reg} > size_m1)
            run_cfg.run_offset = size_m1[POS_W-1:0];
        else
            run_cfg.run_offset = start_offset_reg;
    end

endmodule

`default_nettype wire

/* rtl/core/utf8_truncating_copy_top.sv */
// Top level of the UTF-8 whole-character bounded string copy.
// Depends on utc_pkg, utc_in_if, utc_out_if, utc_cfg_if, utc_cfg_regs and the assert header.
// The block takes one source byte per clock and gives at most one destination write per
// byte, in the cycle after the byte's transfer, through a single output register; src.ready
// stays high except while that register holds a write that dst has not yet taken, so the
// sustained rate is one byte per cycle. Register values take effect at the next byte that
// has first set. Each run ends with exactly one terminator write (last = 1) carrying the
// status and the resulting length; bytes after it are dropped until the next first byte.
`default_nettype none

`include "utf8_truncating_copy_top_assert.svh"

module utf8_truncating_copy_top (
    input  wire       clk,
    input  wire       rst_n,
    utc_in_if.sink    src,
    utc_out_if.source dst,
    utc_cfg_if.sink   cfg
);
    import utc_pkg::*;

    run_cfg_t run_cfg;

    // Run state
    logic [POS_W-1:0]      pos_reg,        pos_next;
    logic [LEFT_W-1:0]     left_reg,       left_next;
    logic                  fin_reg,        fin_next;
    logic [BUF_SIZE_W-1:0] run_size_reg,   run_size_next;
    logic [POS_W-1:0]      run_offset_reg, run_offset_next;

    // Output register
    logic                  out_valid_reg;
    logic [BYTE_W-1:0]     write_byte_reg, write_byte_next;
    logic [POS_W-1:0]      write_pos_reg,  write_pos_next;
    logic                  last_reg,       last_next;
    status_t               status_reg,     status_next;
    logic [POS_W-1:0]      total_length_reg, total_length_next;

    logic                  has_result;
    logic                  src_accept;
    logic [LEN_W-1:0]      len;
    logic [POS_W-1:0]      pos_base;
    logic [BUF_SIZE_W-1:0] fit_sum;

    utc_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .run_cfg (run_cfg)
    );

    assign src.ready  = !out_valid_reg || dst.ready;
    assign src_accept = src.valid && src.ready;

    // Position the byte lands at, before any update for this byte
    assign pos_base = src.first ? run_cfg.run_offset : pos_reg;
    assign len      = utc_lead_length(src.src_byte);
    assign fit_sum  = {1'b0, pos_base} + BUF_SIZE_W'(len);

    // Per-byte step: first byte reloads the run, then continuation, end or lead handling
    always_comb
    begin
        if (src.first)
        begin
            pos_next        = run_cfg.run_offset;
            left_next       = '0;
            fin_next        = 1'b0;
            run_size_next   = run_cfg.run_size;
            run_offset_next = run_cfg.run_offset;
        end
        else
        begin
            pos_next        = pos_reg;
            left_next       = left_reg;
            fin_next        = fin_reg;
            run_size_next   = run_size_reg;
            run_offset_next = run_offset_reg;
        end

        has_result        = 1'b0;
        write_byte_next   = src.src_byte;
        write_pos_next    = pos_next;
        last_next         = 1'b0;
        status_next       = STAT_COMPLETE;
        total_length_next = '0;

        if (!fin_next)
        begin
            has_result = 1'b1;
            if (src.src_byte == '0)
            begin
                // terminator, also ends a partial character
                write_byte_next   = '0;
                last_next         = 1'b1;
                total_length_next = pos_next;
                fin_next          = 1'b1;
                left_next         = '0;
            end
            else if (left_next != '0)
            begin
                // continuation byte, copied unchecked
                pos_next  = pos_next + POS_W'(1);
                left_next = left_next - LEFT_W'(1);
            end
            else if (len == '0)
            begin
                // invalid lead byte: terminate at the start offset
                write_byte_next   = '0;
                write_pos_next    = run_offset_next;
                last_next         = 1'b1;
                status_next       = STAT_INVALID;
                total_length_next = run_offset_next;
                fin_next          = 1'b1;
            end
            else if (fit_sum >= run_size_next)
            begin
                // character does not fit with the terminator
                write_byte_next   = '0;
                last_next         = 1'b1;
                status_next       = STAT_TRUNCATED;
                total_length_next = pos_next;
                fin_next          = 1'b1;
            end
            else
            begin
                pos_next  = pos_next + POS_W'(1);
                left_next = LEFT_W'(len - LEN_W'(1));
            end
        end
    end

    // Run state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            left_reg       <= '0;
            fin_reg        <= 1'b1;
            run_size_reg   <= BUF_SIZE_RESET;
            run_offset_reg <= '0;
        end
        else if (src_accept)
        begin
            pos_reg        <= pos_next;
            left_reg       <= left_next;
            fin_reg        <= fin_next;
            run_size_reg   <= run_size_next;
            run_offset_reg <= run_offset_next;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (src_accept)
            out_valid_reg <= has_result;
        else if (dst.ready)
            out_valid_reg <= 1'b0;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (src_accept && has_result)
        begin
            write_byte_reg   <= write_byte_next;
            write_pos_reg    <= write_pos_next;
            last_reg         <= last_next;
            status_reg       <= status_next;
            total_length_reg <= total_length_next;
        end
    end

    assign dst.valid        = out_valid_reg;
    assign dst.write_byte   = write_byte_reg;
    assign dst.write_pos    = write_pos_reg;
    assign dst.last         = last_reg;
    assign dst.status       = status_reg;
    assign dst.total_length = total_length_reg;

    // Checks
    `UTC_ASSERT_IMPLIES(a_term_fields, out_valid_reg && last_reg,
        write_byte_reg == '0 && total_length_reg == write_pos_reg)
    `UTC_ASSERT_IMPLIES(a_data_clean, out_valid_reg && !last_reg,
        status_reg == STAT_COMPLETE && total_length_reg == '0)
    `UTC_ASSERT_IMPLIES(a_idle_no_char, fin_reg, left_reg == '0)
    `UTC_ASSERT_IMPLIES(a_invalid_at_start,
        out_valid_reg && last_reg && status_reg == STAT_INVALID,
        write_pos_reg == run_offset_reg)
    `UTC_ASSERT_NEXT(a_first_at_offset, src_accept && src.first,
        out_valid_reg && write_pos_reg == run_offset_reg)

endmodule

`default_nettype wire
